FILE: hdl/aesbc_pkg.sv
package aesbc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 2;
  localparam int RK_ROWS   = 15;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W3   = 3'd4;

  localparam logic [8:0] KEY_SIZE_128 = 9'd128;
  localparam logic [8:0] KEY_SIZE_192 = 9'd192;
  localparam logic [8:0] KEY_SIZE_256 = 9'd256;

  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef enum logic {ENG_IDLE, ENG_RUN} eng_state_t;

  typedef struct packed {
    logic       busy;
    logic       bad;
    logic [3:0] nr;
  } key_status_t;

  typedef struct packed {
    logic         func;
    logic         bad;
    logic [127:0] block;
  } q_item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte n of the state sits at bits [127-8n -: 8]; byte 4c+r is row r of column c.
  function automatic logic [127:0] sub_bytes(logic [127:0] s, logic inv);
    logic [127:0] t;
    t = '0;
    for (int n = 0; n < 16; n++) begin
      t[127-8*n -: 8] = inv ? INV_SBOX[s[127-8*n -: 8]] : SBOX[s[127-8*n -: 8]];
    end
    return t;
  endfunction

  function automatic logic [127:0] shift_rows(logic [127:0] s, logic inv);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127-8*(4*((c+r)%4)+r) -: 8] = s[127-8*(4*c+r) -: 8];
        end else begin
          t[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+r)%4)+r) -: 8];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] mix_col(logic [31:0] col, logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [31:0] o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      a[r]  = col[31-8*r -: 8];
      x2[r] = xtime(a[r]);
      x4[r] = xtime(x2[r]);
      x8[r] = xtime(x4[r]);
    end
    for (int r = 0; r < 4; r++) begin
      if (inv) begin
        o[31-8*r -: 8] = (x8[r] ^ x4[r] ^ x2[r])
                       ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
                       ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
                       ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
      end else begin
        o[31-8*r -: 8] = x2[r] ^ (x2[(r+1)%4] ^ a[(r+1)%4]) ^ a[(r+2)%4] ^ a[(r+3)%4];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(logic [127:0] s, logic inv);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      t[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
    end
    return t;
  endfunction

endpackage

FILE: hdl/aesbc_if.sv
interface aesbc_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  modport source (output valid, func, block_hi, block_lo, input ready);
  modport sink (input valid, func, block_hi, block_lo, output ready);
endinterface

interface aesbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_hi;
  logic [63:0] out_lo;
  logic        status;
  modport source (output valid, out_hi, out_lo, status, input ready);
  modport sink (input valid, out_hi, out_lo, status, output ready);
endinterface

interface aesbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/aesbc_key_sched.sv
module aesbc_key_sched (
  input  logic                   clk,
  input  logic                   rst,
  aesbc_cfg_if.sink              cfg,
  input  logic [3:0]             rk_addr,
  output logic [127:0]           rk_data,
  output aesbc_pkg::key_status_t ks
);

  logic [8:0]   key_size;
  logic [63:0]  key_word [4];
  logic [127:0] rk [aesbc_pkg::RK_ROWS];
  logic [31:0]  win [8];
  logic         busy;
  logic [5:0]   widx;
  logic [2:0]   kmod;
  logic [7:0]   rcon;
  logic [3:0]   nk;
  logic [3:0]   nr;
  logic         bad;
  logic         wr;
  logic [2:0]   nk_m1;
  logic [63:0]  kw_sel;
  logic [31:0]  key_wd;
  logic [31:0]  prev_nk;
  logic [31:0]  new_word;
  logic         last_word;

  assign cfg.ready = 1'b1;
  assign wr = cfg.valid && cfg.ready && (cfg.index <= aesbc_pkg::REG_KEY_W3);

  always_comb begin
    bad = 1'b0;
    unique case (key_size)
      aesbc_pkg::KEY_SIZE_128: begin nk = 4'd4; nr = 4'd10; end
      aesbc_pkg::KEY_SIZE_192: begin nk = 4'd6; nr = 4'd12; end
      aesbc_pkg::KEY_SIZE_256: begin nk = 4'd8; nr = 4'd14; end
      default: begin nk = 4'd4; nr = 4'd10; bad = 1'b1; end
    endcase
  end

  assign nk_m1     = 3'(nk - 4'd1);
  assign kw_sel    = key_word[widx[2:1]];
  assign key_wd    = widx[0] ? kw_sel[31:0] : kw_sel[63:32];
  assign prev_nk   = win[nk_m1];
  assign last_word = (widx == {nr, 2'b11});

  always_comb begin
    if (widx < {2'b00, nk}) begin
      new_word = key_wd;
    end else if (kmod == 3'd0) begin
      new_word = prev_nk ^ aesbc_pkg::sub_word({win[0][23:0], win[0][31:24]}) ^ {rcon, 24'h0};
    end else if (nk == 4'd8 && kmod == 3'd4) begin
      new_word = prev_nk ^ aesbc_pkg::sub_word(win[0]);
    end else begin
      new_word = prev_nk ^ win[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size <= aesbc_pkg::KEY_SIZE_128;
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
      busy <= 1'b1;
      widx <= '0;
      kmod <= '0;
      rcon <= 8'h01;
    end else if (wr) begin
      if (cfg.index == aesbc_pkg::REG_KEY_SIZE) begin
        key_size <= cfg.data[8:0];
      end else begin
        key_word[2'(cfg.index - aesbc_pkg::REG_KEY_W0)] <= cfg.data;
      end
      busy <= 1'b1;
      widx <= '0;
      kmod <= '0;
      rcon <= 8'h01;
    end else if (busy) begin
      widx <= widx + 6'd1;
      kmod <= (kmod == nk_m1) ? 3'd0 : kmod + 3'd1;
      if (widx >= {2'b00, nk} && kmod == 3'd0) rcon <= aesbc_pkg::xtime(rcon);
      busy <= !last_word;
    end
  end

  // Round keys are built one word per cycle; the last eight words form the
  // window that the recurrence looks back into.
  always_ff @(posedge clk) begin
    if (busy && !wr && !rst) begin
      rk[widx[5:2]][127-32*widx[1:0] -: 32] <= new_word;
      win[0] <= new_word;
      for (int i = 1; i < 8; i++) win[i] <= win[i-1];
    end
  end

  assign rk_data = rk[rk_addr];
  assign ks = '{busy: busy, bad: bad, nr: nr};

endmodule

FILE: hdl/aesbc_front.sv
module aesbc_front (
  input  logic                   clk,
  input  logic                   rst,
  aesbc_req_if.sink              req,
  input  aesbc_pkg::key_status_t ks,
  output aesbc_pkg::q_item_t     head,
  output logic                   head_valid,
  input  logic                   pop
);

  aesbc_pkg::q_item_t q [aesbc_pkg::QDEPTH];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;

  assign req.ready  = !ks.busy && (count != 2'(aesbc_pkg::QDEPTH));
  assign push       = req.valid && req.ready;
  assign head       = q[rptr];
  assign head_valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // The key size is classified on entry so the engine can skip invalid items.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= '{func: req.func, bad: ks.bad, block: {req.block_hi, req.block_lo}};
    end
  end

endmodule

FILE: hdl/aesbc_engine.sv
module aesbc_engine (
  input  logic                   clk,
  input  logic                   rst,
  input  aesbc_pkg::q_item_t     head,
  input  logic                   head_valid,
  output logic                   pop,
  input  aesbc_pkg::key_status_t ks,
  output logic [3:0]             rk_addr,
  input  logic [127:0]           rk_data,
  aesbc_rsp_if.source            rsp
);

  aesbc_pkg::eng_state_t st;
  aesbc_pkg::eng_state_t st_next;
  logic [127:0] blk;
  logic [127:0] blk_next;
  logic         func;
  logic [3:0]   rnd;
  logic [3:0]   rnd_next;
  logic [3:0]   steps;
  logic [3:0]   steps_next;
  logic         slot_free;
  logic         last;
  logic [127:0] enc_sr;
  logic [127:0] enc_out;
  logic [127:0] dec_ark;
  logic [127:0] dec_out;
  logic [127:0] round_out;
  logic         load_out;
  logic [127:0] out_blk;
  logic         out_status;

  assign slot_free = !rsp.valid || rsp.ready;
  assign last      = (steps == 4'd1);

  assign enc_sr  = aesbc_pkg::shift_rows(aesbc_pkg::sub_bytes(blk, 1'b0), 1'b0);
  assign enc_out = (last ? enc_sr : aesbc_pkg::mix_columns(enc_sr, 1'b0)) ^ rk_data;
  assign dec_ark = aesbc_pkg::sub_bytes(aesbc_pkg::shift_rows(blk, 1'b1), 1'b1) ^ rk_data;
  assign dec_out = last ? dec_ark : aesbc_pkg::mix_columns(dec_ark, 1'b1);
  assign round_out = (func == aesbc_pkg::FUNC_DEC) ? dec_out : enc_out;

  always_comb begin
    st_next    = st;
    blk_next   = blk;
    rnd_next   = rnd;
    steps_next = steps;
    pop        = 1'b0;
    load_out   = 1'b0;
    out_blk    = round_out;
    out_status = aesbc_pkg::STATUS_OK;
    rk_addr    = rnd;
    unique case (st)
      aesbc_pkg::ENG_IDLE: begin
        rk_addr = (head.func == aesbc_pkg::FUNC_DEC) ? ks.nr : 4'd0;
        if (head_valid) begin
          if (head.bad) begin
            if (slot_free) begin
              pop        = 1'b1;
              load_out   = 1'b1;
              out_blk    = '0;
              out_status = aesbc_pkg::STATUS_BAD;
            end
          end else begin
            pop        = 1'b1;
            blk_next   = head.block ^ rk_data;
            rnd_next   = (head.func == aesbc_pkg::FUNC_DEC) ? ks.nr - 4'd1 : 4'd1;
            steps_next = ks.nr;
            st_next    = aesbc_pkg::ENG_RUN;
          end
        end
      end
      aesbc_pkg::ENG_RUN: begin
        if (!last) begin
          blk_next   = round_out;
          rnd_next   = (func == aesbc_pkg::FUNC_DEC) ? rnd - 4'd1 : rnd + 4'd1;
          steps_next = steps - 4'd1;
        end else if (slot_free) begin
          load_out = 1'b1;
          st_next  = aesbc_pkg::ENG_IDLE;
        end
      end
      default: st_next = aesbc_pkg::ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= aesbc_pkg::ENG_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      st <= st_next;
      if (load_out) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    blk   <= blk_next;
    rnd   <= rnd_next;
    steps <= steps_next;
    if (pop) func <= head.func;
    if (load_out) begin
      rsp.out_hi <= out_blk[127:64];
      rsp.out_lo <= out_blk[63:0];
      rsp.status <= out_status;
    end
  end

endmodule

FILE: hdl/aes_block_encrypt_decrypt_top.sv
// AES-128/192/256 block cipher and inverse cipher.
// Channel req carries one item: func (0 encrypt, 1 decrypt) and the block as
// block_hi/block_lo, byte 0 most significant. Channel rsp returns one item per
// request in order: out_hi/out_lo and status (1 when the key size is invalid,
// with a zero block). Channel cfg writes index 0 key size in bits, 1..4 key words.
// Every key write starts round key expansion, one word per cycle, 4*(Nr+1)
// words (44, 52 or 60); req.ready stays low meanwhile. Reset loads a zero
// 128-bit key and runs the same expansion before the first item is taken.
// An accepted item enters a two-entry queue; the round engine does one round
// per cycle. Invalid items skip the rounds and go straight to the output
// register. The result is held in an output register: while rsp is stalled
// the engine stops at its final round and the queue keeps taking items until
// it fills, after which req.ready drops.
module aes_block_encrypt_decrypt_top (
  input logic         clk,
  input logic         rst,
  aesbc_req_if.sink   req,
  aesbc_rsp_if.source rsp,
  aesbc_cfg_if.sink   cfg
);

  aesbc_pkg::key_status_t ks;
  aesbc_pkg::q_item_t     head;
  logic                   head_valid;
  logic                   pop;
  logic [3:0]             rk_addr;
  logic [127:0]           rk_data;

  aesbc_key_sched u_key (
    .clk(clk), .rst(rst), .cfg(cfg), .rk_addr(rk_addr), .rk_data(rk_data), .ks(ks)
  );

  aesbc_front u_front (
    .clk(clk), .rst(rst), .req(req), .ks(ks),
    .head(head), .head_valid(head_valid), .pop(pop)
  );

  aesbc_engine u_eng (
    .clk(clk), .rst(rst), .head(head), .head_valid(head_valid), .pop(pop),
    .ks(ks), .rk_addr(rk_addr), .rk_data(rk_data), .rsp(rsp)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_during_expand: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> !ks.busy)
    else $error("item accepted while round keys were being expanded");

  a_bad_status_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |-> (rsp.out_hi == 64'd0 && rsp.out_lo == 64'd0))
    else $error("invalid key size result carries a nonzero block");

  a_key_write_expands: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready && cfg.index <= aesbc_pkg::REG_KEY_W3) |=> ks.busy)
    else $error("key write did not start round key expansion");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("engine took an item from an empty queue");
`endif

endmodule
